// File: rtl/core/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// shared types and constants of the vertical thrust plant step block
// ----------------------------------------------------------------------------
package vtp_pkg;

  // payload of one input transfer
  typedef struct packed {
    logic signed [17:0] ctl_cmd;
    logic signed [31:0] disturbance_accel;
  } in_t;

  // payload of one result transfer
  typedef struct packed {
    logic signed [47:0] altitude;
    logic signed [31:0] vertical_velocity;
    logic        [16:0] actual_thrust;
  } out_t;

  // configuration register file
  typedef struct packed {
    logic [30:0] gravity;
    logic [30:0] full_accel;
    logic [16:0] thr_floor;
    logic [16:0] thr_ceil;
    logic [16:0] thr_hover;
    logic [30:0] damping;
    logic [16:0] response_alpha;
    logic [16:0] time_step;
  } cfg_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRAVITY        = 3'd0,
    REG_FULL_ACCEL     = 3'd1,
    REG_THR_FLOOR      = 3'd2,
    REG_THR_CEIL       = 3'd3,
    REG_THR_HOVER      = 3'd4,
    REG_DAMPING        = 3'd5,
    REG_RESPONSE_ALPHA = 3'd6,
    REG_TIME_STEP      = 3'd7
  } cfg_idx_t;

  localparam cfg_t CFG_RESET = '{
    gravity:          31'd642908,
    full_accel:       31'd1285816,
    thr_floor:        17'd0,
    thr_ceil:         17'd65536,
    thr_hover:        17'd32768,
    damping:          31'd0,
    response_alpha:   17'd65536,
    time_step:        17'd655
  };

  // thrust state reload on a hover register write
  typedef struct packed {
    logic        vld;
    logic [16:0] val;
  } thr_load_t;

  localparam logic [16:0] THRUST_RESET = 17'd32768;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MS_THR = 3'd0,  // |thrust error| * alpha
    MS_ACC = 3'd1,  // thrust * full_accel
    MS_DMP = 3'd2,  // |velocity| * damping
    MS_NLO = 3'd3,  // |net accel| low word * time_step
    MS_NHI = 3'd4,  // |net accel| high part * time_step
    MS_ALT = 3'd5   // |velocity| * time_step
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'd0,
    S_MUL_THR = 4'd1,
    S_UPD_THR = 4'd2,
    S_MUL_ACC = 4'd3,
    S_MUL_DMP = 4'd4,
    S_NET     = 4'd5,
    S_MUL_NLO = 4'd6,
    S_MUL_NHI = 4'd7,
    S_NSUM    = 4'd8,
    S_VEL     = 4'd9,
    S_MUL_ALT = 4'd10,
    S_ALT     = 4'd11
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic     ld_in;
    mul_sel_t mul_sel;
    logic     upd_thr;
    logic     ld_net;
    logic     upd_net;
    logic     ld_acc;
    logic     ld_mag;
    logic     upd_vel;
    logic     upd_alt;
  } dp_cmd_t;

endpackage

// File: rtl/core/vtp_cfg_regs.sv
// ----------------------------------------------------------------------------
// vtp_cfg_regs
// configuration register file, with thrust reload on hover writes
// ----------------------------------------------------------------------------
module vtp_cfg_regs
  import vtp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg,
  output thr_load_t           thr_load
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt      = cfg_r;
    thr_load.vld = 1'b0;
    thr_load.val = cfg_data[16:0];
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GRAVITY:        cfg_nxt.gravity          = cfg_data[30:0];
        REG_FULL_ACCEL:     cfg_nxt.full_accel       = cfg_data[30:0];
        REG_THR_FLOOR:      cfg_nxt.thr_floor        = cfg_data[16:0];
        REG_THR_CEIL:       cfg_nxt.thr_ceil         = cfg_data[16:0];
        REG_THR_HOVER: begin
          cfg_nxt.thr_hover = cfg_data[16:0];
          thr_load.vld      = 1'b1;
        end
        REG_DAMPING:        cfg_nxt.damping          = cfg_data[30:0];
        REG_RESPONSE_ALPHA: cfg_nxt.response_alpha   = cfg_data[16:0];
        REG_TIME_STEP:      cfg_nxt.time_step        = cfg_data[16:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/vtp_ctrl.sv
// ----------------------------------------------------------------------------
// vtp_ctrl
// sequencer for one plant tick and the result valid flag
// ----------------------------------------------------------------------------
module vtp_ctrl
  import vtp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_MUL_THR;
      S_MUL_THR: state_nxt = S_UPD_THR;
      S_UPD_THR: state_nxt = S_MUL_ACC;
      S_MUL_ACC: state_nxt = S_MUL_DMP;
      S_MUL_DMP: state_nxt = S_NET;
      S_NET:     state_nxt = S_MUL_NLO;
      S_MUL_NLO: state_nxt = S_MUL_NHI;
      S_MUL_NHI: state_nxt = S_NSUM;
      S_NSUM:    state_nxt = S_VEL;
      S_VEL:     state_nxt = S_MUL_ALT;
      S_MUL_ALT: state_nxt = S_ALT;
      S_ALT:     if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MS_THR;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
      end
      S_MUL_THR: cmd.mul_sel = MS_THR;
      S_UPD_THR: cmd.upd_thr = 1'b1;
      S_MUL_ACC: cmd.mul_sel = MS_ACC;
      S_MUL_DMP: begin
        cmd.mul_sel = MS_DMP;
        cmd.ld_net  = 1'b1;
      end
      S_NET:     cmd.upd_net = 1'b1;
      S_MUL_NLO: cmd.mul_sel = MS_NLO;
      S_MUL_NHI: begin
        cmd.mul_sel = MS_NHI;
        cmd.ld_acc  = 1'b1;
      end
      S_NSUM:    cmd.ld_mag  = 1'b1;
      S_VEL:     cmd.upd_vel = 1'b1;
      S_MUL_ALT: cmd.mul_sel = MS_ALT;
      S_ALT: begin
        // keep the altitude product in place while the result slot is busy
        cmd.mul_sel = MS_ALT;
        cmd.upd_alt = slot_free;
        if (slot_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/vtp_dp.sv
// ----------------------------------------------------------------------------
// vtp_dp
// plant datapath: shared multiplier, rounding, state and result registers
// ----------------------------------------------------------------------------
module vtp_dp
  import vtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  thr_load_t thr_load,
  input  in_t       in_data,
  input  dp_cmd_t   cmd,
  output out_t      out_data
);

  localparam logic signed [18:0] CMD_LO  = -19'sd65536;
  localparam logic signed [18:0] CMD_HI  = 19'sd65536;
  localparam logic signed [48:0] VEL_HI  = 49'sd2147483647;
  localparam logic signed [48:0] VEL_LO  = -49'sd2147483648;
  localparam logic signed [48:0] ALT_HI  = 49'sd140737488355327;
  localparam logic signed [48:0] ALT_LO  = -49'sd140737488355328;
  localparam logic        [16:0] ONE_Q16 = 17'd65536;
  localparam logic        [63:0] RND_Q16 = 64'd32768;

  // state
  logic        [16:0] thr_r;
  logic signed [31:0] vel_r;
  logic signed [47:0] alt_r;
  // working registers
  logic signed [17:0] diff_r;
  logic signed [31:0] dist_r;
  logic        [63:0] prod_r;
  logic signed [47:0] net_r;
  logic        [49:0] acc_r;
  logic        [47:0] mag_r;
  out_t               out_r;

  // input side: desired thrust and error against actual
  logic signed [18:0] cmd_x, cmd_c, des_sum, des_c, lo19, hi19;
  logic signed [17:0] diff_in;

  always_comb begin
    cmd_x = {in_data.ctl_cmd[17], in_data.ctl_cmd};
    lo19  = $signed({2'b00, cfg.thr_floor});
    hi19  = $signed({2'b00, cfg.thr_ceil});
    priority if (cmd_x < CMD_LO) cmd_c = CMD_LO;
    else if (cmd_x > CMD_HI)     cmd_c = CMD_HI;
    else                         cmd_c = cmd_x;
    des_sum = $signed({2'b00, cfg.thr_hover}) + cmd_c;
    priority if (des_sum < lo19) des_c = lo19;
    else if (des_sum > hi19)     des_c = hi19;
    else                         des_c = des_sum;
    diff_in = $signed({1'b0, des_c[16:0]}) - $signed({1'b0, thr_r});
  end

  // magnitudes for the unsigned multiplier
  logic [17:0] diff_mag;
  logic [31:0] vel_mag;
  logic [47:0] net_mag;
  logic [16:0] alpha_sat;

  assign diff_mag  = diff_r[17] ? 18'(-diff_r) : 18'(diff_r);
  assign vel_mag   = vel_r[31] ? (~vel_r + 32'd1) : vel_r;
  assign net_mag   = net_r[47] ? (~net_r + 48'd1) : net_r;
  assign alpha_sat = (cfg.response_alpha > ONE_Q16) ? ONE_Q16 : cfg.response_alpha;

  logic [31:0] mul_a, mul_b;

  always_comb begin
    unique case (cmd.mul_sel)
      MS_THR: begin
        mul_a = 32'(diff_mag);
        mul_b = 32'(alpha_sat);
      end
      MS_ACC: begin
        mul_a = 32'(thr_r);
        mul_b = 32'(cfg.full_accel);
      end
      MS_DMP: begin
        mul_a = vel_mag;
        mul_b = 32'(cfg.damping);
      end
      MS_NLO: begin
        mul_a = net_mag[31:0];
        mul_b = 32'(cfg.time_step);
      end
      MS_NHI: begin
        mul_a = 32'(net_mag[46:32]);
        mul_b = 32'(cfg.time_step);
      end
      MS_ALT: begin
        mul_a = vel_mag;
        mul_b = 32'(cfg.time_step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounded product, nearest with ties away from zero on the magnitude
  logic [63:0] prod_sum;
  logic [47:0] prod_rnd;

  assign prod_sum = prod_r + RND_Q16;
  assign prod_rnd = prod_sum[63:16];

  // actuator lag and thrust clamp
  logic signed [19:0] thr_sum, thr_new, lo20, hi20;

  always_comb begin
    lo20 = $signed({3'b000, cfg.thr_floor});
    hi20 = $signed({3'b000, cfg.thr_ceil});
    if (diff_r[17]) thr_sum = $signed({3'b000, thr_r}) - $signed({2'b00, prod_rnd[17:0]});
    else            thr_sum = $signed({3'b000, thr_r}) + $signed({2'b00, prod_rnd[17:0]});
    priority if (thr_sum < lo20) thr_new = lo20;
    else if (thr_sum > hi20)     thr_new = hi20;
    else                         thr_new = thr_sum;
  end

  // net acceleration
  logic signed [47:0] net_base, drag, net_new;

  assign net_base = $signed({15'b0, prod_rnd[32:0]}) - $signed({17'b0, cfg.gravity})
                  + $signed({{16{dist_r[31]}}, dist_r});
  assign drag     = $signed({1'b0, prod_rnd[46:0]});
  assign net_new  = vel_r[31] ? (net_r + drag) : (net_r - drag);

  // wide product of net magnitude and time step, split in two words
  logic [63:0] nprod;

  assign nprod = {prod_r[31:0], 32'b0} + 64'(acc_r);

  // velocity and altitude integration with saturation
  logic signed [48:0] vel_sum, vel_new, alt_sum, alt_new;

  always_comb begin
    if (net_r[47]) vel_sum = $signed({{17{vel_r[31]}}, vel_r}) - $signed({1'b0, mag_r});
    else           vel_sum = $signed({{17{vel_r[31]}}, vel_r}) + $signed({1'b0, mag_r});
    priority if (vel_sum > VEL_HI) vel_new = VEL_HI;
    else if (vel_sum < VEL_LO)     vel_new = VEL_LO;
    else                           vel_new = vel_sum;

    if (vel_r[31]) alt_sum = $signed({alt_r[47], alt_r}) - $signed({1'b0, prod_rnd});
    else           alt_sum = $signed({alt_r[47], alt_r}) + $signed({1'b0, prod_rnd});
    priority if (alt_sum > ALT_HI) alt_new = ALT_HI;
    else if (alt_sum < ALT_LO)     alt_new = ALT_LO;
    else                           alt_new = alt_sum;
  end

  // plant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRUST_RESET;
      vel_r <= '0;
      alt_r <= '0;
    end else begin
      if (thr_load.vld)     thr_r <= thr_load.val;
      else if (cmd.upd_thr) thr_r <= thr_new[16:0];
      if (cmd.upd_vel)      vel_r <= vel_new[31:0];
      if (cmd.upd_alt)      alt_r <= alt_new[47:0];
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.ld_in) begin
      diff_r <= diff_in;
      dist_r <= in_data.disturbance_accel;
    end
    if (cmd.ld_net)  net_r <= net_base;
    if (cmd.upd_net) net_r <= net_new;
    if (cmd.ld_acc)  acc_r <= prod_r[49:0] + 50'(RND_Q16);
    if (cmd.ld_mag)  mag_r <= nprod[63:16];
    if (cmd.upd_alt) begin
      out_r.altitude          <= alt_new[47:0];
      out_r.vertical_velocity <= vel_r;
      out_r.actual_thrust     <= thr_r;
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/core/vertical_thrust_plant_step_top.sv
// ----------------------------------------------------------------------------
// vertical_thrust_plant_step_top
// result: flagged valid by the last step once the result slot is free
// one item at a time: the chain of six products runs through the one
//   shared 32x32 multiplier, and no new input is taken until it ends
// reset: synchronous, clears altitude and velocity, thrust to hover value
// ----------------------------------------------------------------------------
module vertical_thrust_plant_step_top
  import vtp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t      cfg;
  thr_load_t thr_load;
  dp_cmd_t   cmd;

  // writes always taken; user keeps software writes only while idle
  assign cfg_ready = 1'b1;

  // configuration registers; a hover write also reloads actual thrust
  vtp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .thr_load  (thr_load)
  );

  // sequencer: one step per cycle, waits in the last step while the
  // result register still holds an untaken transfer
  vtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: thrust lag, net acceleration, euler integration
  vtp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .thr_load (thr_load),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/vtp_checker.sv
// ----------------------------------------------------------------------------
// vtp_checker
// port level checks of the plant step block, bound to the top level
// ----------------------------------------------------------------------------
module vtp_checker
  import vtp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // result held until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // one item at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is at work");

  // a new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an item at work");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind vertical_thrust_plant_step_top vtp_checker u_vtp_checker (.*);
